/* hdl/lcar_pkg.sv */
// lcar_pkg: shared constants and types for the load cell converter reader
// no dependencies; used by lcar_rsp_if, lcar_div100, the top level and the bench
package lcar_pkg;

   localparam int unsigned SAMPLE_BITS = 24;
   localparam int unsigned COUNT_W     = $clog2(SAMPLE_BITS + 1);
   localparam int unsigned RAW_W       = 24;
   localparam int unsigned QUOT_W      = 18;
   localparam int unsigned SCALE_W     = 16;
   localparam int unsigned WEIGHT_W    = 16;
   localparam int unsigned PROD_W      = QUOT_W + SCALE_W;

   // floor(x / 100) == (x * ceil(2^31 / 100)) >> 31 for every 24-bit x
   localparam int unsigned DIV_SHIFT   = 31;
   localparam int unsigned DIV_MULT_W  = 25;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT = 25'd21474837;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd15946;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_HIGH,
      PHASE_LOW,
      PHASE_EXTRA
   } phase_type;

endpackage

/* hdl/lcar_req_if.sv */
// lcar_req_if: request channel, one tick of the converter serial line
// depends on nothing beyond the valid/ready handshake
interface lcar_req_if;
   logic valid;
   logic ready;
   logic data_pin;
   logic tare_request;

   modport source (output valid, output data_pin, output tare_request, input ready);
   modport sink (input valid, input data_pin, input tare_request, output ready);
endinterface

/* hdl/lcar_rsp_if.sv */
// lcar_rsp_if: response channel, pin level and conversion result per tick
// depends on lcar_pkg for the field widths
interface lcar_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          clock_pin;
   logic                          result_valid;
   logic                          tare_taken;
   logic [lcar_pkg::RAW_W-1:0]    raw_count;
   logic [lcar_pkg::WEIGHT_W-1:0] weight;

   modport source (output valid, output clock_pin, output result_valid, output tare_taken,
                   output raw_count, output weight, input ready);
   modport sink (input valid, input clock_pin, input result_valid, input tare_taken,
                 input raw_count, input weight, output ready);
endinterface

/* hdl/lcar_div100.sv */
// lcar_div100: divide a 24-bit count by 100 with a reciprocal multiply
// depends on lcar_pkg for widths and the reciprocal constant
module lcar_div100 (
   input  logic [lcar_pkg::RAW_W-1:0]  dividend,
   output logic [lcar_pkg::QUOT_W-1:0] quotient
);

   logic [lcar_pkg::RAW_W+lcar_pkg::DIV_MULT_W-1:0] product;

   assign product  = {{lcar_pkg::DIV_MULT_W{1'b0}}, dividend}
                   * {{lcar_pkg::RAW_W{1'b0}}, lcar_pkg::DIV_MULT};
   assign quotient = product[lcar_pkg::DIV_SHIFT +: lcar_pkg::QUOT_W];

endmodule

/* hdl/load_cell_adc_reader_with_tare_core.sv */
// load_cell_adc_reader_with_tare_core: serial readout of a load cell converter with tare
// depends on lcar_pkg, lcar_req_if, lcar_rsp_if and lcar_div100
//
// Every request is one half period of the converter serial clock and gives exactly one
// response carrying the clock level to drive for that tick. While idle the clock stays
// low until the data line reads low; then 24 pulses shift the count in msb first (sampled
// on the low tick) and one extra pulse follows, after which the response carries the
// offset-corrected raw count and the tare-corrected, scaled weight, clamped to 0..65535.
// A tare request on any tick makes the next finished conversion the new tare instead.
// One request is taken every cycle; the count is divided by 100 on the last low tick and
// the scale multiply happens on the extra tick, each into its own register. The response
// sits in an output register, so requests stall only while that register is full and
// not being taken. The scale reciprocal is written through csr_write_enable/_data.
module load_cell_adc_reader_with_tare_core (
   input  logic                           clock,
   input  logic                           reset,
   lcar_req_if.sink                       req_chan,
   lcar_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [lcar_pkg::SCALE_W-1:0]   csr_write_data
);

   lcar_pkg::phase_type               phase_ff, phase_in;
   logic [lcar_pkg::COUNT_W-1:0]      count_ff, count_in, count_inc;
   logic [lcar_pkg::SAMPLE_BITS-1:0]  shift_ff, shift_in, shift_next;
   logic [lcar_pkg::QUOT_W-1:0]       quot_ff, quot_in, div_quot;
   logic [lcar_pkg::QUOT_W-1:0]       tare_ff, tare_in, diff;
   logic                              pend_ff, pend_in, pend_eff;
   logic [lcar_pkg::SCALE_W-1:0]      scale_ff;
   logic [lcar_pkg::PROD_W-1:0]       product;

   logic                              accept;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              clk_pin_ff, clk_pin_in;
   logic                              res_valid_ff, res_valid_in;
   logic                              taken_ff, taken_in;
   logic [lcar_pkg::RAW_W-1:0]        raw_ff, raw_in;
   logic [lcar_pkg::WEIGHT_W-1:0]     weight_ff, weight_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign count_inc  = count_ff + 1'b1;
   assign shift_next = {shift_ff[lcar_pkg::SAMPLE_BITS-2:0], req_chan.data_pin};
   assign pend_eff   = pend_ff | req_chan.tare_request;
   assign diff       = quot_ff - tare_ff;
   assign product    = {{lcar_pkg::SCALE_W{1'b0}}, diff} * {{lcar_pkg::QUOT_W{1'b0}}, scale_ff};

   // count of the finished shift, top bit flipped, divided by 100
   lcar_div100 u_div100 (
      .dividend ({~shift_next[lcar_pkg::SAMPLE_BITS-1], shift_next[lcar_pkg::SAMPLE_BITS-2:0]}),
      .quotient (div_quot)
   );

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         lcar_pkg::PHASE_IDLE: begin
            if (!req_chan.data_pin) begin
               phase_in = lcar_pkg::PHASE_HIGH;
            end
         end
         lcar_pkg::PHASE_HIGH: begin
            phase_in = lcar_pkg::PHASE_LOW;
         end
         lcar_pkg::PHASE_LOW: begin
            if (count_inc >= lcar_pkg::COUNT_W'(lcar_pkg::SAMPLE_BITS)) begin
               phase_in = lcar_pkg::PHASE_EXTRA;
            end else begin
               phase_in = lcar_pkg::PHASE_HIGH;
            end
         end
         lcar_pkg::PHASE_EXTRA: begin
            phase_in = lcar_pkg::PHASE_IDLE;
         end
         default: begin
            phase_in = lcar_pkg::PHASE_IDLE;
         end
      endcase
   end

   // datapath and response fields
   always_comb begin
      count_in     = count_ff;
      shift_in     = shift_ff;
      quot_in      = quot_ff;
      tare_in      = tare_ff;
      pend_in      = pend_eff;
      clk_pin_in   = 1'b0;
      res_valid_in = 1'b0;
      taken_in     = 1'b0;
      raw_in       = '0;
      weight_in    = '0;
      case (phase_ff)
         lcar_pkg::PHASE_IDLE: begin
            if (!req_chan.data_pin) begin
               shift_in   = '0;
               count_in   = '0;
               clk_pin_in = 1'b1;
            end
         end
         lcar_pkg::PHASE_HIGH: begin
            clk_pin_in = 1'b0;
         end
         lcar_pkg::PHASE_LOW: begin
            shift_in   = shift_next;
            count_in   = count_inc;
            quot_in    = div_quot;
            clk_pin_in = 1'b1;
         end
         lcar_pkg::PHASE_EXTRA: begin
            count_in     = '0;
            res_valid_in = 1'b1;
            raw_in       = {~shift_ff[lcar_pkg::SAMPLE_BITS-1],
                            shift_ff[lcar_pkg::SAMPLE_BITS-2:0]};
            if (pend_eff) begin
               tare_in  = quot_ff;
               pend_in  = 1'b0;
               taken_in = 1'b1;
            end else if (quot_ff > tare_ff) begin
               if (|product[lcar_pkg::PROD_W-1:lcar_pkg::SCALE_W+lcar_pkg::WEIGHT_W]) begin
                  weight_in = '1;
               end else begin
                  weight_in = product[lcar_pkg::SCALE_W +: lcar_pkg::WEIGHT_W];
               end
            end
         end
         default: begin
            clk_pin_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lcar_pkg::PHASE_IDLE;
         count_ff     <= '0;
         shift_ff     <= '0;
         tare_ff      <= '0;
         pend_ff      <= 1'b0;
         scale_ff     <= lcar_pkg::SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            scale_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            shift_ff <= shift_in;
            tare_ff  <= tare_in;
            pend_ff  <= pend_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         quot_ff      <= quot_in;
         clk_pin_ff   <= clk_pin_in;
         res_valid_ff <= res_valid_in;
         taken_ff     <= taken_in;
         raw_ff       <= raw_in;
         weight_ff    <= weight_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.clock_pin    = clk_pin_ff;
   assign rsp_chan.result_valid = res_valid_ff;
   assign rsp_chan.tare_taken   = taken_ff;
   assign rsp_chan.raw_count    = raw_ff;
   assign rsp_chan.weight       = weight_ff;

`ifndef SYNTHESIS
   a_result_clock_low: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.result_valid |-> !rsp_chan.clock_pin)
      else $error("result delivered with clock high");

   a_tare_zero_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.tare_taken |-> rsp_chan.result_valid && rsp_chan.weight == '0)
      else $error("tare response with weight or without result");

   a_extra_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == lcar_pkg::PHASE_EXTRA |=> rsp_chan.valid && rsp_chan.result_valid)
      else $error("extra pulse did not finish a conversion");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lcar_pkg::COUNT_W'(lcar_pkg::SAMPLE_BITS))
      else $error("bit count beyond sample width");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      !accept && !csr_write_enable |=> $stable(phase_ff) && $stable(tare_ff))
      else $error("state moved without an accepted request");
`endif

endmodule

/* tb/tb_load_cell_adc_reader_with_tare_core.sv */
// tb_load_cell_adc_reader_with_tare_core: self-checking bench for the load cell converter reader
// drives serial line ticks, predicts every response and checks each field in order
// depends on lcar_pkg, lcar_req_if, lcar_rsp_if and load_cell_adc_reader_with_tare_core
module tb_load_cell_adc_reader_with_tare_core;

   typedef struct packed {
      logic                          clock_pin;
      logic                          result_valid;
      logic                          tare_taken;
      logic [lcar_pkg::RAW_W-1:0]    raw_count;
      logic [lcar_pkg::WEIGHT_W-1:0] weight;
   } tick_out_type;

   typedef struct packed {
      logic [lcar_pkg::SCALE_W-1:0]  scale;
      logic [2:0]                    idle_high;
      logic [lcar_pkg::RAW_W-1:0]    sample;
      logic                          tare_start;
      logic                          tare_end;
      logic                          typed;
      logic                          exp_taken;
      logic [lcar_pkg::RAW_W-1:0]    exp_raw;
      logic [lcar_pkg::WEIGHT_W-1:0] exp_weight;
   } conv_row_type;

   typedef enum int {
      MODE_STEADY,
      MODE_SEND_GAPS,
      MODE_RECV_STALL,
      MODE_BOTH
   } idle_mode_type;

   localparam int DIR_ROWS     = 11;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_ITEMS  = 40;
   localparam int PHASE_CONVS  = 1;

   logic clock;
   logic reset;
   logic csr_we;
   logic [lcar_pkg::SCALE_W-1:0] csr_data;

   lcar_req_if req_chan();
   lcar_rsp_if rsp_chan();

   load_cell_adc_reader_with_tare_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_we),
      .csr_write_data   (csr_data)
   );

   lcar_pkg::phase_type          rd_phase;
   logic [lcar_pkg::COUNT_W-1:0] rd_bits;
   logic [lcar_pkg::RAW_W-1:0]   rd_shift;
   logic [lcar_pkg::QUOT_W-1:0]  rd_tare;
   logic                         rd_pending;
   logic                         rd_clock;
   logic [lcar_pkg::SCALE_W-1:0] rd_scale;

   tick_out_type  awaited_ticks[$];
   tick_out_type  want_tick;
   conv_row_type  dir_rows [DIR_ROWS];
   idle_mode_type idle_mode;
   int            sent_count;
   int            conv_count;
   int            rsp_count;
   int            mismatch_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("load_cell_adc_reader_with_tare_core regression: fail");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   task automatic step_readout(input logic dp, input logic tr, output tick_out_type res);
      logic [lcar_pkg::RAW_W-1:0]  flipped;
      logic [lcar_pkg::RAW_W-1:0]  quot_full;
      logic [lcar_pkg::QUOT_W-1:0] quot;
      logic [lcar_pkg::PROD_W-1:0] prod;
      res = '0;
      if (tr) rd_pending = 1'b1;
      case (rd_phase)
         lcar_pkg::PHASE_IDLE: begin
            rd_clock = 1'b0;
            if (!dp) begin
               rd_shift = '0;
               rd_bits  = '0;
               rd_clock = 1'b1;
               rd_phase = lcar_pkg::PHASE_HIGH;
            end
         end
         lcar_pkg::PHASE_HIGH: begin
            rd_clock = 1'b0;
            rd_phase = lcar_pkg::PHASE_LOW;
         end
         lcar_pkg::PHASE_LOW: begin
            rd_shift = {rd_shift[lcar_pkg::RAW_W-2:0], dp};
            rd_bits  = rd_bits + 1'b1;
            rd_clock = 1'b1;
            rd_phase = (rd_bits >= lcar_pkg::SAMPLE_BITS) ? lcar_pkg::PHASE_EXTRA
                                                          : lcar_pkg::PHASE_HIGH;
         end
         default: begin
            flipped   = rd_shift ^ {1'b1, {(lcar_pkg::RAW_W-1){1'b0}}};
            quot_full = lcar_pkg::RAW_W'(flipped / 100);
            quot      = quot_full[lcar_pkg::QUOT_W-1:0];
            rd_clock  = 1'b0;
            rd_phase  = lcar_pkg::PHASE_IDLE;
            rd_bits   = '0;
            res.result_valid = 1'b1;
            res.raw_count    = flipped;
            if (rd_pending) begin
               rd_tare        = quot;
               rd_pending     = 1'b0;
               res.tare_taken = 1'b1;
            end else if (quot > rd_tare) begin
               prod = lcar_pkg::PROD_W'(quot - rd_tare) * lcar_pkg::PROD_W'(rd_scale);
               if (prod[lcar_pkg::PROD_W-1:16] > 18'h0FFFF) res.weight = '1;
               else res.weight = prod[31:16];
            end
         end
      endcase
      res.clock_pin = rd_clock;
   endtask

   function automatic bit sender_idles();
      case (idle_mode)
         MODE_SEND_GAPS: return $urandom_range(0, 99) < 70;
         MODE_BOTH:      return $urandom_range(0, 99) < 35;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic logic noise_tare(input bit on);
      return on && ($urandom_range(0, 39) == 0);
   endfunction

   task automatic send_tick(input logic dp, input logic tr, input logic typed,
                            input tick_out_type typed_res);
      tick_out_type res;
      @(negedge clock);
      while (sender_idles()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.data_pin     <= dp;
      req_chan.tare_request <= tr;
      do @(posedge clock); while (!req_chan.ready);
      step_readout(dp, tr, res);
      if (typed && res.result_valid) res = typed_res;
      if (res.result_valid) conv_count++;
      awaited_ticks.push_back(res);
      sent_count++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (awaited_ticks.size() != 0) @(posedge clock);
   endtask

   task automatic write_scale(input logic [lcar_pkg::SCALE_W-1:0] value);
      wait_for_drain();
      @(negedge clock);
      csr_we   <= 1'b1;
      csr_data <= value;
      rd_scale = value;
      @(negedge clock);
      csr_we   <= 1'b0;
   endtask

   task automatic run_conversion(input logic [lcar_pkg::RAW_W-1:0] sample, input int idle_high,
                                 input logic tare_start, input logic tare_end,
                                 input bit noisy, input logic typed,
                                 input tick_out_type typed_res);
      while (rd_phase != lcar_pkg::PHASE_IDLE)
         send_tick(1'($urandom_range(0, 1)), noise_tare(noisy), 1'b0, '0);
      repeat (idle_high) send_tick(1'b1, noise_tare(noisy), 1'b0, '0);
      send_tick(1'b0, tare_start, 1'b0, '0);
      for (int i = lcar_pkg::RAW_W - 1; i >= 0; i--) begin
         send_tick(noisy ? logic'($urandom_range(0, 1)) : ~sample[i], noise_tare(noisy),
                   1'b0, '0);
         send_tick(sample[i], noise_tare(noisy), 1'b0, '0);
      end
      send_tick(1'($urandom_range(0, 1)), tare_end, typed, typed_res);
   endtask

   function automatic logic [lcar_pkg::RAW_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return lcar_pkg::RAW_W'(24'h800000 + $urandom_range(0, 1500));
         1:       return 24'h7FFFFF;
         2:       return 24'hFFFFFF;
         3:       return 24'h000000;
         // near the stored tare
         4:       return lcar_pkg::RAW_W'(rd_tare * 100 + $urandom_range(0, 3000)) ^ 24'h800000;
         default: return lcar_pkg::RAW_W'($urandom);
      endcase
   endfunction

   function automatic logic [lcar_pkg::SCALE_W-1:0] phase_scale(input int p);
      case (p)
         0, 4:    return 16'hFFFF;
         1, 6:    return 16'd1;
         2:       return lcar_pkg::SCALE_RESET;
         default: return lcar_pkg::SCALE_W'($urandom_range(1, 65535));
      endcase
   endfunction

   always @(negedge clock) begin
      case (idle_mode)
         MODE_RECV_STALL: rsp_chan.ready <= $urandom_range(0, 99) >= 70;
         MODE_BOTH:       rsp_chan.ready <= $urandom_range(0, 99) >= 35;
         default:         rsp_chan.ready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_count++;
         if (awaited_ticks.size() == 0) begin
            flag_mismatch($sformatf("response %0d with no request awaiting it", rsp_count));
         end else begin
            want_tick = awaited_ticks.pop_front();
            if (rsp_chan.clock_pin !== want_tick.clock_pin)
               flag_mismatch($sformatf("response %0d clock_pin %0b want %0b", rsp_count,
                                       rsp_chan.clock_pin, want_tick.clock_pin));
            if (rsp_chan.result_valid !== want_tick.result_valid)
               flag_mismatch($sformatf("response %0d result_valid %0b want %0b", rsp_count,
                                       rsp_chan.result_valid, want_tick.result_valid));
            if (rsp_chan.tare_taken !== want_tick.tare_taken)
               flag_mismatch($sformatf("response %0d tare_taken %0b want %0b", rsp_count,
                                       rsp_chan.tare_taken, want_tick.tare_taken));
            if (rsp_chan.raw_count !== want_tick.raw_count)
               flag_mismatch($sformatf("response %0d raw_count %h want %h", rsp_count,
                                       rsp_chan.raw_count, want_tick.raw_count));
            if (rsp_chan.weight !== want_tick.weight)
               flag_mismatch($sformatf("response %0d weight %0d want %0d", rsp_count,
                                       rsp_chan.weight, want_tick.weight));
         end
      end
   end

   initial begin
      int           start_items;
      int           start_convs;
      tick_out_type typed_res;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_data              = '0;
      req_chan.valid        = 1'b0;
      req_chan.data_pin     = 1'b1;
      req_chan.tare_request = 1'b0;
      rsp_chan.ready        = 1'b0;
      idle_mode             = MODE_STEADY;
      sent_count            = 0;
      conv_count            = 0;
      rsp_count             = 0;
      mismatch_count        = 0;
      rd_phase              = lcar_pkg::PHASE_IDLE;
      rd_bits               = '0;
      rd_shift              = '0;
      rd_tare               = '0;
      rd_pending            = 1'b0;
      rd_clock              = 1'b0;
      rd_scale              = lcar_pkg::SCALE_RESET;

      // scale, idle high ticks, sample, tare at start, tare at end, typed, taken, raw, weight
      dir_rows[0]  = '{16'd0, 3'd1, 24'h800000, 1'b0, 1'b0, 1'b1, 1'b0, 24'h000000, 16'h0000};
      dir_rows[1]  = '{16'd0, 3'd0, 24'h7FFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 16'h0000};
      dir_rows[2]  = '{16'd0, 3'd2, 24'hFFFFFF, 1'b1, 1'b0, 1'b1, 1'b1, 24'h7FFFFF, 16'h0000};
      dir_rows[3]  = '{16'd0, 3'd0, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b0, 24'h800000, 16'h0000};
      dir_rows[4]  = '{16'd0, 3'd1, 24'h800000, 1'b0, 1'b0, 1'b1, 1'b0, 24'h000000, 16'h0000};
      dir_rows[5]  = '{16'd0, 3'd0, 24'h7FFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 16'h0000};
      dir_rows[6]  = '{16'd0, 3'd0, 24'h800000, 1'b1, 1'b0, 1'b1, 1'b1, 24'h000000, 16'h0000};
      dir_rows[7]  = '{16'hFFFF, 3'd0, 24'h7FFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 24'hFFFFFF,
                       16'hFFFF};
      dir_rows[8]  = '{lcar_pkg::SCALE_RESET, 3'd0, 24'hA5A5A5, 1'b0, 1'b1, 1'b0, 1'b0,
                       24'h000000, 16'h0000};
      dir_rows[9]  = '{16'd0, 3'd3, 24'h123456, 1'b1, 1'b0, 1'b1, 1'b1, 24'h923456, 16'h0000};
      dir_rows[10] = '{16'd1, 3'd0, 24'h7FFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 16'h0000};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_rows[r].scale != 0 && dir_rows[r].scale != rd_scale)
            write_scale(dir_rows[r].scale);
         typed_res = '{1'b0, 1'b1, dir_rows[r].exp_taken, dir_rows[r].exp_raw,
                       dir_rows[r].exp_weight};
         run_conversion(dir_rows[r].sample, int'(dir_rows[r].idle_high),
                        dir_rows[r].tare_start, dir_rows[r].tare_end, 1'b0,
                        dir_rows[r].typed, typed_res);
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         write_scale(phase_scale(p));
         idle_mode   = idle_mode_type'(p % 4);
         start_items = sent_count;
         start_convs = conv_count;
         while (sent_count - start_items < PHASE_ITEMS ||
                conv_count - start_convs < PHASE_CONVS) begin
            if ($urandom_range(0, 9) == 0) wait_for_drain();
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 20))
                  send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0, 1'b0, '0);
            run_conversion(pick_sample(), $urandom_range(0, 3), $urandom_range(0, 7) == 0,
                           $urandom_range(0, 7) == 0, 1'b1, 1'b0, '0);
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (awaited_ticks.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", awaited_ticks.size()));
      if (mismatch_count == 0) begin
         $display("load_cell_adc_reader_with_tare_core regression: pass");
      end else begin
         $display("load_cell_adc_reader_with_tare_core regression: fail");
      end
      $finish;
   end

endmodule
